[sv/olid_pkg.sv]
// types and constants shared by the ordered list cells and the top level
`default_nettype none
package olid_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DISPLAY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } t_state;

    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic del;
        logic rot;
    } t_cell_ctl;

endpackage
`default_nettype wire

[sv/ordered_list_insert_delete.sv]
// ordered list of signed values kept in a chain of cells, with insert, delete and display
//
//  beat      | direction | strobe            | payload
//  ----------+-----------+-------------------+--------------------------------
//  command   | in        | start && !busy    | i_cmd, i_operand_value
//  result    | out       | o_valid           | o_status, o_element, o_last
//
// insert and delete leave busy low; a command may follow in the next cycle
// display holds busy while the ring of occupied cells rotates once, one entry
//   a cycle, head of the chain on o_element
// results appear in the cycle after the edge that accepts or produces them
// synchronous active-low reset empties the list; the receiver cannot stall
`default_nettype none
module ordered_list_insert_delete #(
    parameter int DEPTH = olid_pkg::DEFAULT_DEPTH
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire [1:0]                              i_cmd,
    input  wire logic signed [olid_pkg::DATA_W-1:0] i_operand_value,
    output logic                                   o_valid,
    output logic [1:0]                             o_status,
    output logic signed [olid_pkg::DATA_W-1:0]     o_element,
    output logic                                   o_last
);
    import olid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_left;
    logic [CW-1:0]            n_left;
    logic                     r_valid;
    logic                     n_valid;
    logic [1:0]               r_status;
    logic [1:0]               n_status;
    logic signed [DATA_W-1:0] r_element;
    logic signed [DATA_W-1:0] n_element;
    logic                     r_last;
    logic                     n_last;

    t_cell_ctl                ctl;
    logic                     accept;
    logic                     full;
    logic                     found;
    logic [DEPTH:0]           hit;
    logic signed [DATA_W-1:0] value [DEPTH];

    assign accept = start && (r_state == ST_IDLE);
    assign full   = r_count == CW'(DEPTH);
    assign found  = hit[DEPTH];
    assign hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] left_value;
            logic signed [DATA_W-1:0] right_value;
            if (g == 0) begin : g_first
                assign left_value = i_operand_value;
            end else begin : g_inner_left
                assign left_value = value[g-1];
            end
            if (g == DEPTH - 1) begin : g_final
                assign right_value = '0;
            end else begin : g_inner_right
                assign right_value = value[g+1];
            end
            olid_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_count       (r_count),
                .i_key         (i_operand_value),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .i_head        (value[0]),
                .i_hit         (hit[g]),
                .o_hit         (hit[g+1]),
                .o_value       (value[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_DISPLAY) && (r_count != '0)) begin
                    n_state = ST_SHOW;
                end
            end
            ST_SHOW: begin
                if (r_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        ctl       = '0;
        n_count   = r_count;
        n_left    = r_left;
        n_valid   = 1'b0;
        n_status  = STS_DONE;
        n_element = '0;
        n_last    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_cmd)
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (full) begin
                                n_status = STS_FULL;
                            end else begin
                                ctl.ins_front = i_cmd == CMD_INS_FRONT;
                                ctl.ins_back  = i_cmd == CMD_INS_BACK;
                                n_count       = r_count + CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (found) begin
                                ctl.del = 1'b1;
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = STS_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_left  = r_count;
                            end
                        end
                    endcase
                end
            end
            ST_SHOW: begin
                ctl.rot   = 1'b1;
                n_valid   = 1'b1;
                n_element = value[0];
                n_last    = r_left == CW'(1);
                n_left    = r_left - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_element <= n_element;
        r_last    <= n_last;
    end

    assign busy      = r_state != ST_IDLE;
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_last    = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_show_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHOW) |-> (r_left != '0) && (r_left <= r_count))
        else $error("display counter out of range");

    a_show_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHOW) && (r_left == CW'(1)) |=> !busy && o_valid && o_last)
        else $error("display did not close with a last beat");

    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (i_cmd == CMD_INS_FRONT || i_cmd == CMD_INS_BACK)
        |=> o_valid && (o_status == STS_FULL) && $stable(r_count))
        else $error("insert into full list not reported");

endmodule
`default_nettype wire

[sv/olid_cell.sv]
// one list slot: holds an entry, matches a key and moves data to or from its neighbours
`default_nettype none
module olid_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire                                    i_clk,
    input  wire olid_pkg::t_cell_ctl               i_ctl,
    input  wire [CW-1:0]                           i_count,
    input  wire logic signed [olid_pkg::DATA_W-1:0] i_key,
    input  wire logic signed [olid_pkg::DATA_W-1:0] i_left_value,
    input  wire logic signed [olid_pkg::DATA_W-1:0] i_right_value,
    input  wire logic signed [olid_pkg::DATA_W-1:0] i_head,
    input  wire                                    i_hit,
    output logic                                   o_hit,
    output logic signed [olid_pkg::DATA_W-1:0]     o_value
);
    import olid_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     occupied;
    logic                     at_back;
    logic                     is_tail;
    logic                     match;

    assign occupied = CW'(IDX) < i_count;
    assign at_back  = CW'(IDX) == i_count;
    assign is_tail  = CW'(IDX + 1) == i_count;
    assign match    = occupied && (r_value == i_key);
    assign o_hit    = i_hit | match;
    assign o_value  = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_front) begin
            n_value = i_left_value;
        end else if (i_ctl.ins_back && at_back) begin
            n_value = i_key;
        end else if (i_ctl.del && (i_hit || match)) begin
            n_value = i_right_value;
        end else if (i_ctl.rot) begin
            n_value = is_tail ? i_head : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

[tb/tb_ordered_list_insert_delete.sv]
// testbench for ordered_list_insert_delete: directed table then random commands
module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    localparam int LIST_DEPTH   = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 370;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = LIST_DEPTH + 8;

    typedef struct {
        t_status            st;
        logic signed [31:0] elem;
        logic               last;
    } t_list_result;

    // typed rows always expect element zero and last set
    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] val;
        bit                 typed;
        t_status            st;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_cmd = CMD_INS_FRONT;
    logic signed [31:0] i_operand_value = '0;
    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_element;
    logic               o_last;

    logic signed [31:0] list_model[$];
    t_list_result       pending_results[$];
    t_stim_row          stim_table[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;

    ordered_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_operand_value(i_operand_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_element      (o_element),
        .o_last         (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ordered_list_insert_delete verification failed");
            $finish;
        end
    end

    function automatic void expect_result(input t_status st, input logic signed [31:0] elem,
                                          input logic last);
        t_list_result r;
        r.st   = st;
        r.elem = elem;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_list_command(input t_cmd c, input logic signed [31:0] v);
        int hit;
        hit = -1;
        case (c)
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (list_model.size() >= LIST_DEPTH) begin
                    expect_result(STS_FULL, '0, 1'b1);
                end else begin
                    if (c == CMD_INS_FRONT) list_model.push_front(v);
                    else list_model.push_back(v);
                    expect_result(STS_DONE, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                for (int i = 0; i < list_model.size() && hit < 0; i++)
                    if (list_model[i] == v) hit = i;
                if (hit < 0) begin
                    expect_result(STS_NOT_FOUND, '0, 1'b1);
                end else begin
                    list_model.delete(hit);
                    expect_result(STS_DONE, '0, 1'b1);
                end
            end
            default: begin
                if (list_model.size() == 0)
                    expect_result(STS_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_model.size(); i++)
                        expect_result(STS_DONE, list_model[i], i == list_model.size() - 1);
            end
        endcase
    endfunction

    // results are checked on the edge that ends their cycle
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat status %0d element %0d last %0b",
                         $time, o_status, o_element, o_last);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.st || o_element !== exp_r.elem
                    || o_last !== exp_r.last) begin
                    $display("%0t: mismatch expected status %0d element %0d last %0b",
                             $time, exp_r.st, exp_r.elem, exp_r.last);
                    $display("%0t:          actual   status %0d element %0d last %0b",
                             $time, o_status, o_element, o_last);
                    error_count++;
                end
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            $display("%0t: o_valid expected 0 actual %b", $time, o_valid);
            error_count++;
        end
    end

    task automatic issue(input t_cmd c, input logic signed [31:0] v);
        i_cmd           <= c;
        i_operand_value <= v;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_list_command(c, v);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_row(input t_cmd c, input logic signed [31:0] v,
                                    input bit typed, input t_status st);
        t_stim_row row;
        row.cmd   = c;
        row.val   = v;
        row.typed = typed;
        row.st    = st;
        stim_table.push_back(row);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $signed(32'($urandom_range(0, 8))) - 4;
        if (r < 9) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 70) return (r & 1) ? CMD_INS_BACK : CMD_INS_FRONT;
            if (r < 90) return CMD_DELETE;
            return CMD_DISPLAY;
        end
        if (r < 25) return (r & 1) ? CMD_INS_BACK : CMD_INS_FRONT;
        if (r < 85) return CMD_DELETE;
        return CMD_DISPLAY;
    endfunction

    initial begin
        t_cmd               c;
        logic signed [31:0] v;
        bit                 filling;

        add_row(CMD_DISPLAY,   '0,            1'b1, STS_EMPTY);
        add_row(CMD_DELETE,    '0,            1'b1, STS_NOT_FOUND);
        add_row(CMD_INS_FRONT, 32'sh8000_0000, 1'b1, STS_DONE);
        add_row(CMD_INS_BACK,  32'sh7fff_ffff, 1'b1, STS_DONE);
        add_row(CMD_INS_FRONT, -1,            1'b1, STS_DONE);
        add_row(CMD_INS_BACK,  -1,            1'b1, STS_DONE);
        add_row(CMD_DISPLAY,   '0,            1'b0, STS_DONE);
        // duplicate key: only the front copy goes
        add_row(CMD_DELETE,    -1,            1'b1, STS_DONE);
        add_row(CMD_DISPLAY,   32'sh5555_aaaa, 1'b0, STS_DONE);
        add_row(CMD_DELETE,    5,             1'b1, STS_NOT_FOUND);
        for (int i = 0; i < LIST_DEPTH - 3; i++)
            add_row((i & 1) ? CMD_INS_BACK : CMD_INS_FRONT,
                    32'(i) * 32'sh1111_1111 ^ 32'shf0f0_0f0f, 1'b1, STS_DONE);
        // list full from here
        add_row(CMD_INS_FRONT, 1,             1'b1, STS_FULL);
        add_row(CMD_INS_BACK,  2,             1'b1, STS_FULL);
        add_row(CMD_DISPLAY,   '0,            1'b0, STS_DONE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            issue(stim_table[k].cmd, stim_table[k].val);
            if (stim_table[k].typed) begin
                pending_results.pop_back();
                expect_result(stim_table[k].st, '0, 1'b1);
            end
            pace();
        end
        drain();

        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) filling = !filling || list_model.size() < 4;
            c = pick_cmd(filling);
            if (c == CMD_DELETE && list_model.size() != 0 && $urandom_range(0, 9) < 6)
                v = list_model[$urandom_range(0, list_model.size() - 1)];
            else
                v = pick_value();
            issue(c, v);
            if (n % 100 == 99) drain();
            else pace();
        end

        drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ordered_list_insert_delete verification clean");
        else
            $display("ordered_list_insert_delete verification failed");
        $finish;
    end
endmodule
